// File: hdl/pvd_pkg.sv
`timescale 1ns / 1ps
package pvd_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_PIX
  } pvd_state_t;

  // request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  // register indexes
  localparam logic CFG_WIDE_IDX = 1'b0;
  localparam logic CFG_HIGH_IDX = 1'b1;
  localparam logic [2:0] LOG2_MAX = 3'd6;

  // fetch sequence: nine neighbours then the own block
  localparam logic [3:0] OWN_SEL    = 4'd9;
  localparam logic [3:0] FETCH_LAST = 4'd10;
  localparam logic [3:0] PIX_LAST   = 4'd15;

  // channel order: 0 red, 1 green, 2 blue, 3 alpha
  typedef logic [3:0][7:0] pvd_rgba_t;

  typedef struct packed {
    logic       store_wr;
    logic       latch_req;
    logic       rd_en;
    logic [3:0] rd_sel;
    logic       cap_en;
    logic [3:0] cap_sel;
    logic       pix_go;
    logic [3:0] pix_idx;
  } pvd_cmd_t;

  typedef struct packed {
    logic pix_room;
  } pvd_sts_t;

  function automatic logic [7:0] widen3(input logic [2:0] v);
    return {v, v, v[2:1]};
  endfunction

  function automatic logic [7:0] widen4(input logic [3:0] v);
    return {v, v};
  endfunction

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic pvd_rgba_t colour_a(input logic [15:0] v);
    pvd_rgba_t c;
    if (v[15]) begin
      c[0] = widen5(v[14:10]);
      c[1] = widen5(v[9:5]);
      c[2] = widen5(v[4:0]);
      c[3] = 8'hFF;
    end else begin
      c[0] = widen4(v[11:8]);
      c[1] = widen4(v[7:4]);
      c[2] = widen4(v[3:0]);
      c[3] = widen3(v[14:12]);
    end
    return c;
  endfunction

  function automatic pvd_rgba_t colour_b(input logic [15:0] v);
    pvd_rgba_t c;
    if (v[15]) begin
      c[0] = widen5(v[14:10]);
      c[1] = widen5(v[9:5]);
      c[2] = widen4(v[4:1]);
      c[3] = 8'hFF;
    end else begin
      c[0] = widen4(v[11:8]);
      c[1] = widen4(v[7:4]);
      c[2] = widen3(v[3:1]);
      c[3] = widen3(v[14:12]);
    end
    return c;
  endfunction

  // modulation weight in eighths toward colour a
  function automatic logic [3:0] mod_weight(input logic mode, input logic [1:0] code);
    logic [3:0] w;
    case (code)
      2'd0:    w = 4'd0;
      2'd1:    w = mode ? 4'd3 : 4'd4;
      2'd2:    w = mode ? 4'd5 : 4'd4;
      default: w = 4'd8;
    endcase
    return w;
  endfunction

  // neighbour column / row offset (0..2) for fetch slot 0..8
  function automatic logic [1:0] nb_col(input logic [3:0] sel);
    logic [1:0] c;
    case (sel)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] nb_row(input logic [3:0] sel);
    logic [1:0] r;
    case (sel)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [11:0] morton(input logic [5:0] x, input logic [5:0] y);
    logic [11:0] m;
    for (int k = 0; k < 6; k++) begin
      m[2*k]   = y[k];
      m[2*k+1] = x[k];
    end
    return m;
  endfunction

endpackage

// File: hdl/pvd_if.sv
`timescale 1ns / 1ps
interface pvd_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [11:0] block_index;
  logic [63:0] block_word;
  modport source(output valid, req_type, block_index, block_word, input ready);
  modport sink(input valid, req_type, block_index, block_word, output ready);
endinterface

interface pvd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last_pixel;
  modport source(output valid, pixel_x, pixel_y, red, green, blue, alpha, last_pixel,
                 input ready);
  modport sink(input valid, pixel_x, pixel_y, red, green, blue, alpha, last_pixel,
               output ready);
endinterface

// File: hdl/pvd_ram.sv
`timescale 1ns / 1ps
module pvd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                          wdata,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule

// File: hdl/pvd_ctrl.sv
`timescale 1ns / 1ps
module pvd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_req_type,
  output logic            in_ready,
  input  pvd_pkg::pvd_sts_t sts,
  output pvd_pkg::pvd_cmd_t cmd
);
  import pvd_pkg::*;

  pvd_state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_req_type == REQ_DECODE) begin
          state_nxt = ST_FETCH;
          cnt_nxt   = 4'd0;
        end
      end
      ST_FETCH: begin
        if (cnt_r == FETCH_LAST) begin
          state_nxt = ST_PIX;
          cnt_nxt   = 4'd0;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      ST_PIX: begin
        if (sts.pix_room) begin
          if (cnt_r == PIX_LAST) begin
            state_nxt = ST_IDLE;
          end
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = 4'd0;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.store_wr  = in_valid && in_req_type == REQ_LOAD;
        cmd.latch_req = in_valid && in_req_type == REQ_DECODE;
      end
      ST_FETCH: begin
        cmd.rd_en   = cnt_r != FETCH_LAST;
        cmd.rd_sel  = cnt_r;
        cmd.cap_en  = cnt_r != 4'd0;
        cmd.cap_sel = cnt_r - 4'd1;
      end
      ST_PIX: begin
        cmd.pix_go  = sts.pix_room;
        cmd.pix_idx = cnt_r;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  a_fetch_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH && cnt_r == FETCH_LAST) |=> (state_r == ST_PIX && cnt_r == 4'd0))
    else $error("fetch did not hand over to pixel phase");
  a_fetch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> (cnt_r <= FETCH_LAST))
    else $error("fetch counter overran");
  a_pix_only: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pix_go |-> (state_r == ST_PIX && !cmd.rd_en && !cmd.store_wr))
    else $error("pixel issued outside pixel phase");
  a_block_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pix_go && cnt_r == PIX_LAST) |=> (state_r == ST_IDLE))
    else $error("block did not end after sixteenth pixel");
endmodule

// File: hdl/pvd_dp.sv
`timescale 1ns / 1ps
module pvd_dp #(
  parameter int MAX_BLOCKS = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pvd_pkg::pvd_cmd_t cmd,
  output pvd_pkg::pvd_sts_t sts,
  input  logic [2:0]        wide_log2,
  input  logic [2:0]        high_log2,
  input  logic [11:0]       in_block_index,
  input  logic [63:0]       in_block_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_pixel_x,
  output logic [7:0]        out_pixel_y,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic [7:0]        out_alpha,
  output logic              out_last_pixel
);
  import pvd_pkg::*;

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  // remainder by the store depth through constant compare and subtract
  function automatic logic [AW-1:0] store_addr(input logic [11:0] raw);
    logic [11:0] r;
    r = raw;
    for (int k = 11; k >= 0; k--) begin
      if ((longint'(MAX_BLOCKS) << k) <= 64'd4095) begin
        if (r >= 12'(MAX_BLOCKS << k)) begin
          r = r - 12'(MAX_BLOCKS << k);
        end
      end
    end
    return AW'(r);
  endfunction

  logic [5:0]  bx_r, by_r;
  logic [5:0]  wmask, hmask;
  logic [5:0]  cx, cy;
  logic [AW-1:0] ram_addr;
  logic [63:0] ram_rdata;
  pvd_rgba_t   nb_a_r [9];
  pvd_rgba_t   nb_b_r [9];
  logic [31:0] mod_r;
  logic        mode_r;

  // latch block position of a decode request
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      for (int k = 0; k < 6; k++) begin
        by_r[k] <= in_block_index[2*k];
        bx_r[k] <= in_block_index[2*k+1];
      end
    end
  end

  assign wmask = 6'((7'd1 << wide_log2) - 7'd1);
  assign hmask = 6'((7'd1 << high_log2) - 7'd1);

  // neighbour position for the current fetch slot
  always_comb begin
    if (cmd.rd_sel == OWN_SEL) begin
      cx = bx_r;
      cy = by_r;
    end else begin
      cx = (bx_r + 6'(nb_col(cmd.rd_sel)) - 6'd1) & wmask;
      cy = (by_r + 6'(nb_row(cmd.rd_sel)) - 6'd1) & hmask;
    end
    ram_addr = cmd.store_wr ? store_addr(in_block_index) : store_addr(morton(cx, cy));
  end

  pvd_ram #(.WIDTH(64), .DEPTH(MAX_BLOCKS)) u_store (
    .clk   (clk),
    .we    (cmd.store_wr),
    .re    (cmd.rd_en),
    .addr  (ram_addr),
    .wdata (in_block_word),
    .rdata (ram_rdata)
  );

  // capture expanded neighbour colours and own modulation data
  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      if (cmd.cap_sel == OWN_SEL) begin
        mod_r  <= ram_rdata[31:0];
        mode_r <= ram_rdata[32];
      end else begin
        nb_a_r[cmd.cap_sel] <= colour_a(ram_rdata[63:48]);
        nb_b_r[cmd.cap_sel] <= colour_b(ram_rdata[47:32]);
      end
    end
  end

  // stage a: bilinear sums in 1/16 units
  logic [1:0]  ix, iy, wx, wy;
  logic [2:0]  lx, ly;
  logic [4:0]  w [4];
  logic [3:0]  base;
  logic [3:0]  sel [4];
  logic [13:0] acc_a, acc_b;
  logic [11:0] sa_nxt [4];
  logic [11:0] sb_nxt [4];
  logic [11:0] a_sa_r [4];
  logic [11:0] a_sb_r [4];
  logic [3:0]  a_m_r;
  logic [7:0]  a_x_r, a_y_r;
  logic        a_last_r;
  logic        a_valid_r;
  logic        out_valid_r;
  logic        b_load, a_move;

  always_comb begin
    ix   = cmd.pix_idx[1:0];
    iy   = cmd.pix_idx[3:2];
    wx   = ix + 2'd2;
    wy   = iy + 2'd2;
    lx   = 3'd4 - {1'b0, wx};
    ly   = 3'd4 - {1'b0, wy};
    w[0] = 5'(lx) * 5'(ly);
    w[1] = 5'({1'b0, wx}) * 5'(ly);
    w[2] = 5'(lx) * 5'({1'b0, wy});
    w[3] = 5'({1'b0, wx}) * 5'({1'b0, wy});
    base = (iy[1] ? 4'd3 : 4'd0) + {3'd0, ix[1]};
    sel[0] = base;
    sel[1] = base + 4'd1;
    sel[2] = base + 4'd3;
    sel[3] = base + 4'd4;
    for (int c = 0; c < 4; c++) begin
      acc_a = 14'd0;
      acc_b = 14'd0;
      for (int n = 0; n < 4; n++) begin
        acc_a = acc_a + 14'(nb_a_r[sel[n]][c]) * 14'(w[n]);
        acc_b = acc_b + 14'(nb_b_r[sel[n]][c]) * 14'(w[n]);
      end
      sa_nxt[c] = acc_a[11:0];
      sb_nxt[c] = acc_b[11:0];
    end
  end

  // pipeline handshake
  assign b_load       = !out_valid_r || out_ready;
  assign a_move       = a_valid_r && b_load;
  assign sts.pix_room = !a_valid_r || a_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.pix_go) begin
        a_valid_r <= 1'b1;
      end else if (a_move) begin
        a_valid_r <= 1'b0;
      end
      if (a_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_go) begin
      a_sa_r   <= sa_nxt;
      a_sb_r   <= sb_nxt;
      a_m_r    <= mod_weight(mode_r, mod_r[2*cmd.pix_idx +: 2]);
      a_x_r    <= {bx_r, ix};
      a_y_r    <= {by_r, iy};
      a_last_r <= cmd.pix_idx == PIX_LAST;
    end
  end

  // stage b: modulation blend, round to nearest
  logic [14:0] blend [4];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      blend[c] = 15'(a_sb_r[c]) * 15'(4'd8 - a_m_r) + 15'(a_sa_r[c]) * 15'(a_m_r) + 15'd64;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      out_pixel_x    <= a_x_r;
      out_pixel_y    <= a_y_r;
      out_red        <= blend[0][14:7];
      out_green      <= blend[1][14:7];
      out_blue       <= blend[2][14:7];
      out_alpha      <= blend[3][14:7];
      out_last_pixel <= a_last_r;
    end
  end

  assign out_valid = out_valid_r;
endmodule

// File: hdl/pvrtc_4bpp_block_decoder_top.sv
`timescale 1ns / 1ps
// load word: accepted in the idle state, written to the block store at the accepting edge
// decode word: fetch phase (ten store reads for nine neighbours plus own block on
//   one read port, then a last capture), then 16 pixels at one per cycle while stage a has room
// pixels pass the stage a and stage b registers; a new request is accepted only after the 16th pixel
// synchronous active-low reset clears control state, valid flags and size registers; store contents are kept
module pvrtc_4bpp_block_decoder_top #(
  parameter int MAX_BLOCKS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  pvd_in_if.sink      in_ch,
  pvd_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import pvd_pkg::*;

  logic [2:0] wide_log2_r, high_log2_r;
  logic [2:0] wval;
  logic       cfg_wr;
  pvd_cmd_t   cmd;
  pvd_sts_t   sts;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign wval       = (cfg_pwdata[2:0] > LOG2_MAX) ? LOG2_MAX : cfg_pwdata[2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_log2_r <= 3'd0;
      high_log2_r <= 3'd0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == CFG_WIDE_IDX) begin
        wide_log2_r <= wval;
      end else begin
        high_log2_r <= wval;
      end
    end
  end

  assign cfg_prdata = {29'd0, (cfg_paddr[2] == CFG_HIGH_IDX) ? high_log2_r : wide_log2_r};

  pvd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  pvd_dp #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .wide_log2      (wide_log2_r),
    .high_log2      (high_log2_r),
    .in_block_index (in_ch.block_index),
    .in_block_word  (in_ch.block_word),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_pixel_x    (out_ch.pixel_x),
    .out_pixel_y    (out_ch.pixel_y),
    .out_red        (out_ch.red),
    .out_green      (out_ch.green),
    .out_blue       (out_ch.blue),
    .out_alpha      (out_ch.alpha),
    .out_last_pixel (out_ch.last_pixel)
  );
endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import pvd_pkg::*;

  typedef struct {
    logic        req_type;
    logic [11:0] block_index;
    logic [63:0] block_word;
  } req_word_t;

  typedef struct {
    logic [7:0] px;
    logic [7:0] py;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       last;
  } pixel_word_t;

  logic clk;
  logic rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  pvd_in_if  in_ch();
  pvd_out_if out_ch();

  pvrtc_4bpp_block_decoder_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // shadow state of the decoder
  logic [63:0] shadow_store [4096];
  logic [2:0]  wide_log2;
  logic [2:0]  high_log2;

  // store entries that some queued load has written
  bit          written [4096];

  req_word_t   pending_reqs[$];
  pixel_word_t expected_pixels[$];
  req_word_t   cur_req;
  int          fail_count = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  bit          quiet = 0;

  // clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int wid3(input logic [2:0] v);
    return {v, v, v[2:1]};
  endfunction

  function automatic int wid4(input logic [3:0] v);
    return {v, v};
  endfunction

  function automatic int wid5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  // expand colour a (is_b = 0) or colour b (is_b = 1) to rgba
  function automatic void expand_colour(input logic [15:0] v, input bit is_b, output int c[4]);
    if (v[15]) begin
      c[0] = wid5(v[14:10]);
      c[1] = wid5(v[9:5]);
      c[2] = is_b ? wid4(v[4:1]) : wid5(v[4:0]);
      c[3] = 255;
    end else begin
      c[0] = wid4(v[11:8]);
      c[1] = wid4(v[7:4]);
      c[2] = is_b ? wid3(v[3:1]) : wid4(v[3:0]);
      c[3] = wid3(v[14:12]);
    end
  endfunction

  // block at column / row, interleaved into a store index
  function automatic logic [63:0] block_at(input logic [5:0] bx, input logic [5:0] by);
    logic [11:0] idx;
    for (int k = 0; k < 6; k++) begin
      idx[2*k]   = by[k];
      idx[2*k+1] = bx[k];
    end
    return shadow_store[idx];
  endfunction

  // predict the sixteen pixels of one decoded block
  function automatic void decode_pixels(input logic [11:0] idx);
    logic [5:0]  bx, by, mw, mh, x0, y0, x1, y1;
    logic [63:0] own;
    logic [63:0] nb[4];
    int          wt[4];
    int          sa[4], sb[4], ca[4], cb[4];
    int          ix, iy, wx, wy, m;
    logic [1:0]  code;
    pixel_word_t p;
    int          ch_val[4];
    for (int k = 0; k < 6; k++) begin
      by[k] = idx[2*k];
      bx[k] = idx[2*k+1];
    end
    mw = 6'((1 << wide_log2) - 1);
    mh = 6'((1 << high_log2) - 1);
    own = shadow_store[idx];
    for (int i = 0; i < 16; i++) begin
      ix = i & 3;
      iy = i >> 2;
      wx = (ix + 2) & 3;
      wy = (iy + 2) & 3;
      x0 = (bx - 6'(ix < 2)) & mw;
      y0 = (by - 6'(iy < 2)) & mh;
      x1 = (x0 + 6'd1) & mw;
      y1 = (y0 + 6'd1) & mh;
      nb[0] = block_at(x0, y0); wt[0] = (4 - wx) * (4 - wy);
      nb[1] = block_at(x1, y0); wt[1] = wx * (4 - wy);
      nb[2] = block_at(x0, y1); wt[2] = (4 - wx) * wy;
      nb[3] = block_at(x1, y1); wt[3] = wx * wy;
      for (int ch = 0; ch < 4; ch++) begin
        sa[ch] = 0;
        sb[ch] = 0;
      end
      for (int n = 0; n < 4; n++) begin
        expand_colour(nb[n][63:48], 1'b0, ca);
        expand_colour(nb[n][47:32], 1'b1, cb);
        for (int ch = 0; ch < 4; ch++) begin
          sa[ch] += ca[ch] * wt[n];
          sb[ch] += cb[ch] * wt[n];
        end
      end
      // modulation weight in eighths toward colour a
      code = own[2*i +: 2];
      case (code)
        2'd0: m = 0;
        2'd1: m = own[32] ? 3 : 4;
        2'd2: m = own[32] ? 5 : 4;
        default: m = 8;
      endcase
      for (int ch = 0; ch < 4; ch++)
        ch_val[ch] = ((sb[ch] * (8 - m) + sa[ch] * m + 64) >> 7) & 255;
      p.px = 8'(bx * 4 + ix);
      p.py = 8'(by * 4 + iy);
      p.r = 8'(ch_val[0]);
      p.g = 8'(ch_val[1]);
      p.b = 8'(ch_val[2]);
      p.a = 8'(ch_val[3]);
      p.last = (i == 15);
      expected_pixels.push_back(p);
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        if (cur_req.req_type == REQ_LOAD)
          shadow_store[cur_req.block_index] = cur_req.block_word;
        else
          decode_pixels(cur_req.block_index);
      end
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.req_type    <= cur_req.req_type;
        in_ch.block_index <= cur_req.block_index;
        in_ch.block_word  <= cur_req.block_word;
        if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 5);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v !== act_v) begin
      $display("%0t: pixel %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // pixel monitor
  always @(posedge clk) begin
    pixel_word_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel word x=%0d y=%0d", $time, out_ch.pixel_x,
                   out_ch.pixel_y);
          fail_count++;
        end else begin
          e = expected_pixels.pop_front();
          check_field("x", e.px, out_ch.pixel_x);
          check_field("y", e.py, out_ch.pixel_y);
          check_field("red", e.r, out_ch.red);
          check_field("green", e.g, out_ch.green);
          check_field("blue", e.b, out_ch.blue);
          check_field("alpha", e.a, out_ch.alpha);
          check_field("last", e.last, out_ch.last_pixel);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 5);
      end
    end
  end

  task automatic cfg_write(input logic reg_idx, input logic [31:0] value);
    logic [2:0] v;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(4 * reg_idx);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    v = value[2:0];
    if (v > LOG2_MAX) v = LOG2_MAX;
    if (reg_idx == CFG_WIDE_IDX) wide_log2 = v;
    else high_log2 = v;
  endtask

  task automatic set_size(input logic [2:0] w, input logic [2:0] h);
    cfg_write(CFG_WIDE_IDX, {24'($urandom_range(0, 255)), 5'b0, w});
    cfg_write(CFG_HIGH_IDX, {24'($urandom_range(0, 255)), 5'b0, h});
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic void push_req(input logic t, input logic [11:0] idx,
                                   input logic [63:0] w);
    req_word_t q;
    q.req_type = t;
    q.block_index = idx;
    q.block_word = w;
    if (t == REQ_LOAD) written[idx] = 1'b1;
    pending_reqs.push_back(q);
  endfunction

  // load a random word into an entry that no load has reached yet
  function automatic void need_block(input logic [11:0] idx);
    if (!written[idx]) push_req(REQ_LOAD, idx, rand_word());
  endfunction

  // decode, after making sure the own block and its neighbours are loaded
  function automatic void push_decode(input logic [11:0] idx, input logic [63:0] w);
    logic [5:0] bx, by, mw, mh, nx, ny;
    for (int k = 0; k < 6; k++) begin
      by[k] = idx[2*k];
      bx[k] = idx[2*k+1];
    end
    mw = 6'((1 << wide_log2) - 1);
    mh = 6'((1 << high_log2) - 1);
    need_block(idx);
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        nx = (bx + 6'(dx) - 6'd1) & mw;
        ny = (by + 6'(dy) - 6'd1) & mh;
        need_block(morton(nx, ny));
      end
    end
    push_req(REQ_DECODE, idx, w);
  endfunction

  // index inside the square spanned by the larger texture side, mostly
  function automatic logic [11:0] rand_index();
    logic [11:0] idx;
    idx = 12'($urandom);
    if ($urandom_range(0, 5) != 0)
      idx = idx & 12'((1 << (2 * ((wide_log2 > high_log2) ? wide_log2 : high_log2))) - 1);
    return idx;
  endfunction

  // wait until every queued request is sent and every expected pixel is seen
  task automatic drain();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    repeat (n) begin
      if ($urandom_range(0, 9) < 6) push_decode(rand_index(), rand_word());
      else push_req(REQ_LOAD, rand_index(), rand_word());
    end
    drain();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.req_type    = REQ_LOAD;
    in_ch.block_index = '0;
    in_ch.block_word  = '0;
    out_ch.ready      = 1'b0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    wide_log2         = '0;
    high_log2         = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    set_size(3'd0, 3'd0);

    // directed: single block, extremes of words and both modes
    push_req(REQ_LOAD, 12'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    push_decode(12'd0, '0);
    push_req(REQ_LOAD, 12'd0, 64'h0000_0000_0000_0000);
    push_decode(12'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    push_req(REQ_LOAD, 12'd0, 64'h8000_8000_E4E4_E4E4);
    push_decode(12'd0, '0);
    push_req(REQ_LOAD, 12'd0, 64'h7FFF_7FFF_1B1B_1B1B);
    push_decode(12'd0, '0);
    push_decode(12'hFFF, '0);
    drain();

    // directed: largest texture, register value seven clamps to six
    set_size(3'd7, 3'd7);
    push_req(REQ_LOAD, 12'hFFF, 64'h8001_7FFF_9C63_A5F0);
    push_decode(12'hFFF, '0);
    push_decode(12'h000, '0);
    push_decode(12'hAAA, '0);
    push_decode(12'h555, '0);
    drain();
    set_size(3'd6, 3'd6);
    push_decode(12'h000, '0);
    push_decode(12'hFFF, '0);
    drain();
    // non-square, block outside the texture
    set_size(3'd1, 3'd0);
    push_decode(12'h002, '0);
    push_decode(12'h801, '0);
    drain();

    // random phases over several sizes
    set_size(3'd2, 3'd1);
    random_phase(28);
    set_size(3'd0, 3'd3);
    random_phase(28);
    set_size(3'd3, 3'd0);
    random_phase(28);
    set_size(3'($urandom_range(0, 2)), 3'($urandom_range(0, 2)));
    random_phase(28);
    quiet = 1;
    set_size(3'd1, 3'd1);
    random_phase(24);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // timeout
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: files.f
hdl/pvd_pkg.sv
hdl/pvd_if.sv
hdl/pvd_ram.sv
hdl/pvd_ctrl.sv
hdl/pvd_dp.sv
hdl/pvrtc_4bpp_block_decoder_top.sv
verif/tb_top.sv
